// ===== rtl/cdps_pkg.sv =====
// ----------------------------------------------------------------------------
// cdps_pkg
// Shared widths, status codes and interface structs of the clock divisor
// pair search unit.
// ----------------------------------------------------------------------------
package cdps_pkg;

    // default divider limits
    localparam int MAIN_DIV_MAX_DEF   = 256;
    localparam int SECOND_DIV_MAX_DEF = 16;

    // field widths
    localparam int RATIO_W  = 17;
    localparam int HALF_W   = RATIO_W - 1;
    localparam int FIXED_W  = 5;
    localparam int STATUS_W = 3;
    localparam int MAIN_W   = 9;
    localparam int SECOND_W = 5;
    localparam int ERR_W    = 10;

    // arithmetic constants
    localparam int PRESCALE = 8;
    localparam int PERMILLE = 1000;

    // scaled difference (diff * 1000) width
    localparam int X_W = HALF_W + ERR_W;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FIXED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ODD   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [X_W-1:0]    dividend;
        logic [HALF_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ERR_W-1:0] quotient;
    } div_rsp_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                prescale_bypass;
        logic [MAIN_W-1:0]   main_divider;
        logic [SECOND_W-1:0] second_divider;
        logic                second_valid;
        logic [ERR_W-1:0]    error_permille;
    } result_t;

endpackage

// ===== rtl/cdps_div.sv =====
// ----------------------------------------------------------------------------
// cdps_div
// Restoring divider, one quotient bit per cycle. Computes the error in
// parts per thousand as diff * 1000 / (ratio / 2); quotient fits ERR_W bits.
// ----------------------------------------------------------------------------
module cdps_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  cdps_pkg::div_req_t req,
    output cdps_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(cdps_pkg::ERR_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [cdps_pkg::X_W-1:0]      rem_reg;
    logic [cdps_pkg::X_W-1:0]      dsh_reg;
    logic [cdps_pkg::ERR_W-1:0]    q_reg;
    logic                          ge;

    // trial subtract against the shifted divisor
    assign ge = (rem_reg >= dsh_reg);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= CNT_W'(cdps_pkg::ERR_W - 1);
            rem_reg <= req.dividend;
            dsh_reg <= cdps_pkg::X_W'(req.divisor) << (cdps_pkg::ERR_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[cdps_pkg::ERR_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== rtl/cdps_core.sv =====
// ----------------------------------------------------------------------------
// cdps_core
// Request checks and search sequencer: walks divider pairs until a zero
// threshold or the last, one per cycle between divides of accepted ones.
// ----------------------------------------------------------------------------
module cdps_core #(
    parameter int MAIN_DIV_MAX   = cdps_pkg::MAIN_DIV_MAX_DEF,
    parameter int SECOND_DIV_MAX = cdps_pkg::SECOND_DIV_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cdps_pkg::RATIO_W-1:0]    in_ratio,
    input  logic                            in_use,
    input  logic [cdps_pkg::FIXED_W-1:0]    in_fixed,
    output logic                            res_valid,
    input  logic                            res_ready,
    output cdps_pkg::result_t               res
);

    // sequencer states
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_INIT = 3'd1;
    localparam logic [STATE_W-1:0] S_SCAN = 3'd2;
    localparam logic [STATE_W-1:0] S_DIVW = 3'd3;
    localparam logic [STATE_W-1:0] S_MULT = 3'd4;
    localparam logic [STATE_W-1:0] S_DONE = 3'd5;

    // derived widths and limits
    localparam int HW     = cdps_pkg::HALF_W;
    localparam int IW     = $clog2(MAIN_DIV_MAX + 1);
    localparam int JW     = $clog2(SECOND_DIV_MAX + 1);
    localparam int P_MAX  = cdps_pkg::PRESCALE * MAIN_DIV_MAX * SECOND_DIV_MAX;
    localparam int PW     = $clog2(P_MAX + 1);
    localparam int CW     = ((PW > HW) ? PW : HW) + 2;
    localparam int THR_B1 = MAIN_DIV_MAX / cdps_pkg::PERMILLE;
    localparam int THR_BS = MAIN_DIV_MAX * SECOND_DIV_MAX / cdps_pkg::PERMILLE;
    localparam int THR_P1 = cdps_pkg::PRESCALE * MAIN_DIV_MAX / cdps_pkg::PERMILLE;
    localparam int THR_PS = P_MAX / cdps_pkg::PERMILLE;
    localparam int THR_TOP = (THR_PS > 1023) ? THR_PS : 1023;
    localparam int TW     = $clog2(THR_TOP + 1);
    localparam int TPW    = TW + HW;
    localparam int MW     = (TPW > cdps_pkg::X_W) ? TPW : cdps_pkg::X_W;
    localparam int LIM_1  = 2 * cdps_pkg::PRESCALE * MAIN_DIV_MAX;
    localparam int LIM_S  = 2 * cdps_pkg::PRESCALE * MAIN_DIV_MAX * SECOND_DIV_MAX;
    localparam int BYP_1  = MAIN_DIV_MAX;
    localparam int BYP_S  = MAIN_DIV_MAX * SECOND_DIV_MAX;

    logic [STATE_W-1:0]        state_reg, state_next;
    logic                      accepted_reg;
    logic [HW-1:0]             ratio_h_reg;
    logic                      use_reg;
    logic                      bypass_reg;
    logic [PW-1:0]             step_reg;
    logic [JW-1:0]             maxfp_reg;
    logic [IW-1:0]             i_reg;
    logic [JW-1:0]             j_reg;
    logic [PW-1:0]             pi_reg;
    logic [PW-1:0]             p_reg;
    logic [TW-1:0]             thresh_reg;
    logic [TPW-1:0]            thr_prod_reg;
    logic [IW-1:0]             cand_main_reg;
    logic [JW-1:0]             cand_second_reg;
    logic                      cand_last_reg;
    logic [IW-1:0]             best_main_reg;
    logic [JW-1:0]             best_second_reg;
    cdps_pkg::result_t         res_reg;

    cdps_pkg::div_req_t        div_req;
    cdps_pkg::div_rsp_t        div_rsp;

    // ------------------------------------------------------------------
    // request checks
    // ------------------------------------------------------------------
    logic                      is_fixed, is_range, is_odd, in_bypass;
    logic [PW-1:0]             in_step;
    logic [TW-1:0]             thr_init;
    cdps_pkg::result_t         early_res;

    always_comb begin
        is_fixed  = in_use && (in_fixed != '0);
        is_range  = (in_ratio < cdps_pkg::RATIO_W'(2)) ||
                    (32'(in_ratio) > (in_use ? 32'(LIM_S) : 32'(LIM_1)));
        is_odd    = in_ratio[0];
        in_bypass = 32'(in_ratio[cdps_pkg::RATIO_W-1:1]) <=
                    (in_use ? 32'(BYP_S) : 32'(BYP_1));
        in_step   = in_bypass ? PW'(1) : PW'(cdps_pkg::PRESCALE);
        if (in_bypass) begin
            thr_init = in_use ? TW'(THR_BS) : TW'(THR_B1);
        end else begin
            thr_init = in_use ? TW'(THR_PS) : TW'(THR_P1);
        end
        early_res = '0;
        priority if (is_fixed) begin
            early_res.status         = cdps_pkg::ST_FIXED;
            early_res.second_divider = in_fixed;
            early_res.second_valid   = 1'b1;
        end else if (is_range) begin
            early_res.status = cdps_pkg::ST_RANGE;
        end else begin
            early_res.status = cdps_pkg::ST_ODD;
        end
    end

    // ------------------------------------------------------------------
    // candidate scoring: window check and error compare, no division
    // ------------------------------------------------------------------
    logic [CW-1:0]             pe, re;
    logic                      is_eq, is_hi, is_lo, scored, take, is_last;
    logic [HW-1:0]             diff;
    logic [cdps_pkg::X_W-1:0]  x_scaled;

    always_comb begin
        pe       = CW'(p_reg);
        re       = CW'(ratio_h_reg);
        is_eq    = (pe == re);
        is_hi    = (pe > re) && (pe < (re << 1));
        is_lo    = (pe < re) && ((pe << 1) > re);
        scored   = is_eq || is_hi || is_lo;
        diff     = is_hi ? HW'(pe - re) : HW'(re - pe);
        x_scaled = cdps_pkg::X_W'(diff) * cdps_pkg::X_W'(cdps_pkg::PERMILLE);
        // floor(diff*1000/R) < thresh  <=>  diff*1000 < thresh*R
        take     = scored && (MW'(x_scaled) < MW'(thr_prod_reg));
        is_last  = (i_reg == IW'(MAIN_DIV_MAX)) && (j_reg == maxfp_reg);
    end

    // next pair: second divider inner, main divider outer
    logic [IW-1:0]             i_next;
    logic [JW-1:0]             j_next;
    logic [PW-1:0]             pi_next, p_next;

    always_comb begin
        if (j_reg == maxfp_reg) begin
            i_next  = i_reg + IW'(1);
            j_next  = JW'(1);
            pi_next = pi_reg + step_reg;
            p_next  = pi_reg + step_reg;
        end else begin
            i_next  = i_reg;
            j_next  = j_reg + JW'(1);
            pi_next = pi_reg;
            p_next  = p_reg + pi_reg;
        end
    end

    // threshold times halved ratio, shared by setup and update
    logic [TPW-1:0]            thr_prod_mul;
    assign thr_prod_mul = TPW'(thresh_reg) * TPW'(ratio_h_reg);

    // ------------------------------------------------------------------
    // result at the end of a search
    // ------------------------------------------------------------------
    logic                      fin_stop;
    cdps_pkg::result_t         fin_res;

    always_comb begin
        fin_stop = (state_reg == S_MULT) ? (thresh_reg == '0)
                                         : (scored && (thresh_reg == '0));
        fin_res  = '0;
        if (!accepted_reg && !fin_stop) begin
            fin_res.status = cdps_pkg::ST_NONE;
        end else begin
            fin_res.status          = cdps_pkg::ST_FOUND;
            fin_res.prescale_bypass = bypass_reg;
            fin_res.second_valid    = use_reg;
            if (accepted_reg) begin
                fin_res.main_divider   = cdps_pkg::MAIN_W'(best_main_reg);
                fin_res.error_permille = thresh_reg[cdps_pkg::ERR_W-1:0];
                if (use_reg) begin
                    fin_res.second_divider = cdps_pkg::SECOND_W'(best_second_reg);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = (is_fixed || is_range || is_odd) ? S_DONE : S_INIT;
                end
            end
            S_INIT: state_next = S_SCAN;
            S_SCAN: begin
                priority if (take) begin
                    state_next = S_DIVW;
                end else if ((scored && (thresh_reg == '0)) || is_last) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    state_next = S_MULT;
                end
            end
            S_MULT: begin
                state_next = ((thresh_reg == '0) || cand_last_reg) ? S_DONE : S_SCAN;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            accepted_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_IDLE) && in_valid) begin
                accepted_reg <= 1'b0;
            end else if ((state_reg == S_DIVW) && div_rsp.done) begin
                accepted_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    res_reg     <= early_res;
                    ratio_h_reg <= in_ratio[cdps_pkg::RATIO_W-1:1];
                    use_reg     <= in_use;
                    bypass_reg  <= in_bypass;
                    step_reg    <= in_step;
                    maxfp_reg   <= in_use ? JW'(SECOND_DIV_MAX) : JW'(1);
                    thresh_reg  <= thr_init;
                    i_reg       <= IW'(1);
                    j_reg       <= JW'(1);
                    pi_reg      <= in_step;
                    p_reg       <= in_step;
                end
            end
            S_INIT: begin
                thr_prod_reg <= thr_prod_mul;
            end
            S_SCAN: begin
                if (take) begin
                    cand_main_reg   <= i_reg;
                    cand_second_reg <= j_reg;
                    cand_last_reg   <= is_last;
                end
                i_reg   <= i_next;
                j_reg   <= j_next;
                pi_reg  <= pi_next;
                p_reg   <= p_next;
                res_reg <= fin_res;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    thresh_reg      <= TW'(div_rsp.quotient);
                    best_main_reg   <= cand_main_reg;
                    best_second_reg <= cand_second_reg;
                end
            end
            S_MULT: begin
                thr_prod_reg <= thr_prod_mul;
                res_reg      <= fin_res;
            end
            default: begin
            end
        endcase
    end

    // shared divider for the error of an accepted pair
    assign div_req.start    = (state_reg == S_SCAN) && take;
    assign div_req.dividend = x_scaled;
    assign div_req.divisor  = ratio_h_reg;

    cdps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIVW))
        else $error("divider finished outside of the wait state");

    a_accepted_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SCAN) && accepted_reg) |-> (thresh_reg < TW'(cdps_pkg::PERMILLE)))
        else $error("accepted error is not below one thousand");

    a_thr_prod_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (thr_prod_reg == thr_prod_mul))
        else $error("scaled threshold out of step with threshold");

    a_none_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == cdps_pkg::ST_NONE))
            |-> ((res.main_divider == '0) && (res.error_permille == '0)))
        else $error("empty result carries divider or error");

endmodule

// ===== rtl/clock_divisor_pair_search_unit.sv =====
// ----------------------------------------------------------------------------
// clock_divisor_pair_search_unit
// Finds the main/second divider pair that best meets a requested divide
// ratio, with the error in parts per thousand.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request item (ratio, second stage enable, fixed
//   second value); m_ channel returns exactly one result item per request.
//   Both are valid/ready; an item moves when valid and ready are both high.
//   The unit takes one request at a time: s_ready is high only while the
//   sequencer is idle.
// Sequence:
//   passthrough, out of range and odd ratio: result straight from the checks.
//   search: the pairs visited (up to MAIN_DIV_MAX * SECOND_DIV_MAX with the
//   stage on, MAIN_DIV_MAX with it off) are scored at one pair per cycle,
//   pausing for each accepted pair, which runs the bit-serial error
//   divider and a threshold update.
// Stall:
//   a finished result sits in the output register until m_ready; the core
//   then takes the next request while it waits, but holds its own next
//   result until the output register frees up.
// Reset: aresetn synchronous, active low; clears both valids and the
//   sequencer, no request or result survives it.
// ----------------------------------------------------------------------------
module clock_divisor_pair_search_unit #(
    parameter int MAIN_DIV_MAX   = cdps_pkg::MAIN_DIV_MAX_DEF,
    parameter int SECOND_DIV_MAX = cdps_pkg::SECOND_DIV_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [cdps_pkg::RATIO_W-1:0]     s_divide_ratio,
    input  logic                             s_use_second_stage,
    input  logic [cdps_pkg::FIXED_W-1:0]     s_fixed_second_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cdps_pkg::STATUS_W-1:0]    m_status,
    output logic                             m_prescale_bypass,
    output logic [cdps_pkg::MAIN_W-1:0]      m_main_divider,
    output logic [cdps_pkg::SECOND_W-1:0]    m_second_divider,
    output logic                             m_second_valid,
    output logic [cdps_pkg::ERR_W-1:0]       m_error_permille
);

    logic              res_valid;
    logic              res_ready;
    cdps_pkg::result_t res;
    logic              m_valid_reg;
    cdps_pkg::result_t out_reg;

    // search core
    cdps_core #(
        .MAIN_DIV_MAX   (MAIN_DIV_MAX),
        .SECOND_DIV_MAX (SECOND_DIV_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_ratio  (s_divide_ratio),
        .in_use    (s_use_second_stage),
        .in_fixed  (s_fixed_second_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register, refilled in the cycle it is emptied
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_prescale_bypass = out_reg.prescale_bypass;
    assign m_main_divider    = out_reg.main_divider;
    assign m_second_divider  = out_reg.second_divider;
    assign m_second_valid    = out_reg.second_valid;
    assign m_error_permille  = out_reg.error_permille;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clock divisor pair search unit: requests go in
// over the s_ channel, every result item is compared against a behavioral
// divider pair search, with random back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int RANDOM_ITEMS  = 116;
    localparam int PHASE_B_START = 70;
    localparam int PHASE_C_START = 120;
    localparam int HOLD_AFTER    = 40;
    localparam int HOLD_CYCLES   = 10000;
    localparam int TAIL_CYCLES   = 4500;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct {
        logic [cdps_pkg::RATIO_W-1:0] ratio;
        logic                         stage_on;
        logic [cdps_pkg::FIXED_W-1:0] fixed_value;
        bit                           drain_first;
    } ratio_request_t;

    logic                          aclk                 = 1'b0;
    logic                          aresetn              = 1'b0;
    logic                          s_valid              = 1'b0;
    logic                          s_ready;
    logic [cdps_pkg::RATIO_W-1:0]  s_divide_ratio       = '0;
    logic                          s_use_second_stage   = 1'b0;
    logic [cdps_pkg::FIXED_W-1:0]  s_fixed_second_value = '0;
    logic                          m_valid;
    logic                          m_ready              = 1'b0;
    logic [cdps_pkg::STATUS_W-1:0] m_status;
    logic                          m_prescale_bypass;
    logic [cdps_pkg::MAIN_W-1:0]   m_main_divider;
    logic [cdps_pkg::SECOND_W-1:0] m_second_divider;
    logic                          m_second_valid;
    logic [cdps_pkg::ERR_W-1:0]    m_error_permille;

    ratio_request_t    ratio_requests[$];
    cdps_pkg::result_t pending_divisor_results[$];

    logic item_taken        = 1'b0;
    logic receive_hold      = 1'b0;
    int   requests_accepted = 0;
    int   results_checked   = 0;
    int   failures          = 0;
    int   cycle_count       = 0;
    int   status_count [8];
    int   sender_idle_pct;
    int   receiver_idle_pct;

    clock_divisor_pair_search_unit u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_divide_ratio       (s_divide_ratio),
        .s_use_second_stage   (s_use_second_stage),
        .s_fixed_second_value (s_fixed_second_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_prescale_bypass    (m_prescale_bypass),
        .m_main_divider       (m_main_divider),
        .m_second_divider     (m_second_divider),
        .m_second_valid       (m_second_valid),
        .m_error_permille     (m_error_permille)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // behavioral divider pair search for one request
    function automatic cdps_pkg::result_t search_divider_pair(
        input logic [cdps_pkg::RATIO_W-1:0] ratio,
        input logic                         stage_on,
        input logic [cdps_pkg::FIXED_W-1:0] fixed_value
    );
        cdps_pkg::result_t res;
        int unsigned       span;
        int unsigned       scale;
        int unsigned       limit;
        int unsigned       half;
        int unsigned       best_main;
        int unsigned       best_second;
        int unsigned       err;
        longint unsigned   prod;
        longint unsigned   diff;
        bit                bypass;
        bit                accepted;
        bit                stopped;
        bit                scored;
        res         = '0;
        span        = stage_on ? cdps_pkg::SECOND_DIV_MAX_DEF : 1;
        best_main   = 0;
        best_second = 0;
        accepted    = 1'b0;
        stopped     = 1'b0;
        diff        = 0;
        // fixed second stage value goes straight through
        if (stage_on && fixed_value != '0) begin
            res.status         = cdps_pkg::ST_FIXED;
            res.second_divider = fixed_value;
            res.second_valid   = 1'b1;
            return res;
        end
        if (ratio < 2 ||
            ratio > 2 * cdps_pkg::PRESCALE * cdps_pkg::MAIN_DIV_MAX_DEF * span) begin
            res.status = cdps_pkg::ST_RANGE;
            return res;
        end
        if (ratio[0]) begin
            res.status = cdps_pkg::ST_ODD;
            return res;
        end
        // prescaler choice and starting threshold
        half   = ratio >> 1;
        bypass = half <= cdps_pkg::MAIN_DIV_MAX_DEF * span;
        scale  = bypass ? 1 : cdps_pkg::PRESCALE;
        limit  = scale * cdps_pkg::MAIN_DIV_MAX_DEF * span / cdps_pkg::PERMILLE;
        // main outer, second inner, both ascending
        for (int main_div = 1; main_div <= cdps_pkg::MAIN_DIV_MAX_DEF && !stopped;
             main_div++) begin
            for (int second_div = 1; second_div <= span && !stopped; second_div++) begin
                prod   = scale * main_div * second_div;
                scored = 1'b1;
                if (prod == half) begin
                    diff = 0;
                end else if (prod / half == 1) begin
                    diff = prod - half;
                end else if (half / prod == 1) begin
                    diff = half - prod;
                end else begin
                    scored = 1'b0;
                end
                if (scored) begin
                    err = 32'(diff * cdps_pkg::PERMILLE / half);
                    if (err < limit) begin
                        limit       = err;
                        best_main   = main_div;
                        best_second = second_div;
                        accepted    = 1'b1;
                    end
                    if (limit == 0) begin
                        stopped = 1'b1;
                    end
                end
            end
        end
        if (!accepted && !stopped) begin
            res.status = cdps_pkg::ST_NONE;
            return res;
        end
        // found, or stopped on a zero starting threshold
        res.status          = cdps_pkg::ST_FOUND;
        res.prescale_bypass = bypass;
        res.main_divider    = accepted ? cdps_pkg::MAIN_W'(best_main) : '0;
        res.second_divider  = (stage_on && accepted) ? cdps_pkg::SECOND_W'(best_second) : '0;
        res.second_valid    = stage_on;
        res.error_permille  = accepted ? cdps_pkg::ERR_W'(limit) : '0;
        return res;
    endfunction

    // random request, mostly well-formed searches
    function automatic ratio_request_t random_request();
        ratio_request_t req;
        int unsigned    pick;
        pick            = $urandom_range(99);
        req.drain_first = 1'b0;
        req.stage_on    = 1'b0;
        req.fixed_value = cdps_pkg::FIXED_W'($urandom_range(cdps_pkg::SECOND_DIV_MAX_DEF));
        req.ratio       = '0;
        if (pick < 25) begin
            // passthrough with any ratio
            req.stage_on    = 1'b1;
            req.fixed_value =
                cdps_pkg::FIXED_W'($urandom_range(cdps_pkg::SECOND_DIV_MAX_DEF, 1));
            req.ratio       = cdps_pkg::RATIO_W'($urandom_range(131071));
        end else if (pick < 35) begin
            // noise over the whole ratio field
            req.stage_on = 1'($urandom_range(1));
            req.ratio    = cdps_pkg::RATIO_W'($urandom_range(131071));
            if (req.stage_on) begin
                req.fixed_value = '0;
            end
        end else if (pick < 45) begin
            // odd ratio inside the range
            req.stage_on = 1'($urandom_range(1));
            if (req.stage_on) begin
                req.fixed_value = '0;
                req.ratio = cdps_pkg::RATIO_W'(2 * $urandom_range(32767) + 1);
            end else begin
                req.ratio = cdps_pkg::RATIO_W'(2 * $urandom_range(2047) + 1);
            end
        end else if (pick < 80) begin
            // single stage search
            req.ratio = cdps_pkg::RATIO_W'(2 * $urandom_range(2048, 1));
        end else begin
            // two stage search
            req.stage_on    = 1'b1;
            req.fixed_value = '0;
            req.ratio       = cdps_pkg::RATIO_W'(2 * $urandom_range(32768, 1));
        end
        return req;
    endfunction

    task automatic queue_request(
        input int unsigned ratio,
        input bit          stage_on,
        input int unsigned fixed_value
    );
        ratio_request_t req;
        req.ratio       = cdps_pkg::RATIO_W'(ratio);
        req.stage_on    = stage_on;
        req.fixed_value = cdps_pkg::FIXED_W'(fixed_value);
        req.drain_first = 1'b0;
        ratio_requests.push_back(req);
    endtask

    task automatic compare_field(input string field, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            failures++;
        end
    endtask

    // idle mix per phase of the run
    always_comb begin
        if (requests_accepted < PHASE_B_START) begin
            sender_idle_pct   = 6;
            receiver_idle_pct = 56;
        end else if (requests_accepted < PHASE_C_START) begin
            sender_idle_pct   = 56;
            receiver_idle_pct = 6;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
    end

    // request driver
    always @(negedge aclk) begin : drive_requests
        ratio_request_t req;
        logic           next_valid;
        next_valid = s_valid;
        if (aresetn && (!s_valid || item_taken)) begin
            next_valid = 1'b0;
            if (ratio_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                if (!ratio_requests[0].drain_first || pending_divisor_results.size() == 0) begin
                    req                  = ratio_requests.pop_front();
                    s_divide_ratio       <= req.ratio;
                    s_use_second_stage   <= req.stage_on;
                    s_fixed_second_value <= req.fixed_value;
                    next_valid           = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
    end

    // accepted request -> expected result
    always @(posedge aclk) begin : track_requests
        cdps_pkg::result_t prediction;
        item_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            prediction = search_divider_pair(s_divide_ratio, s_use_second_stage,
                                             s_fixed_second_value);
            pending_divisor_results.push_back(prediction);
            status_count[prediction.status] = status_count[prediction.status] + 1;
            requests_accepted <= requests_accepted + 1;
        end
    end

    // result ready with random stalls
    always @(negedge aclk) begin : drive_result_ready
        m_ready <= !receive_hold && ($urandom_range(99) >= receiver_idle_pct);
    end

    // long output stall so the unit backs up onto its input
    initial begin : long_result_hold
        while (requests_accepted < HOLD_AFTER) @(posedge aclk);
        receive_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        receive_hold = 1'b0;
    end

    // result monitor
    always @(posedge aclk) begin : check_results
        cdps_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_divisor_results.size() == 0) begin
                $error("result item with no request outstanding, status %0d", m_status);
                failures++;
            end else begin
                want = pending_divisor_results.pop_front();
                compare_field("status", want.status, m_status);
                compare_field("prescale_bypass", want.prescale_bypass, m_prescale_bypass);
                compare_field("main_divider", want.main_divider, m_main_divider);
                compare_field("second_divider", want.second_divider, m_second_divider);
                compare_field("second_valid", want.second_valid, m_second_valid);
                compare_field("error_permille", want.error_permille, m_error_permille);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("clock_divisor_pair_search_unit verification failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : run_sequence
        ratio_request_t req;
        foreach (status_count[idx]) status_count[idx] = 0;

        // directed: edges of range, parity, prescaler choice and passthrough
        queue_request(0, 1'b0, 0);
        queue_request(1, 1'b0, 0);
        queue_request(2, 1'b0, 0);
        queue_request(3, 1'b0, 0);
        queue_request(514, 1'b0, 0);
        queue_request(4096, 1'b0, 0);
        queue_request(4097, 1'b0, 0);
        queue_request(4098, 1'b0, 0);
        queue_request(512, 1'b0, 0);
        queue_request(514, 1'b1, 0);
        queue_request(65536, 1'b1, 0);
        queue_request(65537, 1'b1, 0);
        queue_request(131071, 1'b1, 0);
        queue_request(131070, 1'b0, 0);
        queue_request(0, 1'b1, 1);
        queue_request(131071, 1'b1, 16);
        queue_request(1000, 1'b0, 16);
        queue_request(8194, 1'b1, 0);
        queue_request(8192, 1'b1, 0);
        queue_request(8186, 1'b1, 0);
        queue_request(2, 1'b1, 0);
        queue_request(2000, 1'b0, 0);
        queue_request(4, 1'b1, 8);
        queue_request(43690, 1'b1, 0);

        // random part, sender drains at each phase change
        for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
            req = random_request();
            req.drain_first = (idx == 0) ||
                              (ratio_requests.size() == PHASE_B_START) ||
                              (ratio_requests.size() == PHASE_C_START);
            ratio_requests.push_back(req);
        end

        // reset
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for all requests taken, then all results back
        while (ratio_requests.size() != 0 || s_valid) @(negedge aclk);
        while (pending_divisor_results.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("checked %0d results: %0d found, %0d no pair, %0d passthrough",
                 results_checked, status_count[cdps_pkg::ST_FOUND],
                 status_count[cdps_pkg::ST_NONE], status_count[cdps_pkg::ST_FIXED]);
        $display("rejected %0d out of range and %0d odd, with a long output stall and drains",
                 status_count[cdps_pkg::ST_RANGE], status_count[cdps_pkg::ST_ODD]);
        if (failures == 0) begin
            $display("clock_divisor_pair_search_unit verification clean");
        end else begin
            $display("clock_divisor_pair_search_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cdps_pkg.sv
rtl/cdps_div.sv
rtl/cdps_core.sv
rtl/clock_divisor_pair_search_unit.sv
sim/tb_top.sv
